// File: rtl/fcat_pkg.sv
// ----------------------------------------------------------------------------
// fcat_pkg
// Shared types and codes for the four channel compare alarm timer.
// ----------------------------------------------------------------------------
package fcat_pkg;

  localparam int unsigned DEF_COUNTER_BITS = 32;
  localparam int unsigned DEF_NUM_CHANNELS = 4;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned CHAN_W      = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned COUNT_OUT_W = 32;
  localparam int unsigned FCH_W       = 2;
  localparam int unsigned PRESCALE_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_ARM_ABS = 3'd1;
  localparam logic [OP_W-1:0] OP_ARM_REL = 3'd2;
  localparam logic [OP_W-1:0] OP_DISARM  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_PRESCALER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNTER_EN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_EN   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [CHAN_W-1:0]  channel;
    logic [VALUE_W-1:0] value;
  } fcat_item_t;

  typedef struct packed {
    logic [COUNT_OUT_W-1:0] counter_value;
    logic                   fired;
    logic [FCH_W-1:0]       fired_channel;
    logic                   error;
  } fcat_result_t;

  typedef struct packed {
    logic [PRESCALE_W-1:0] prescaler;
    logic                  counter_enable;
    logic                  alarm_irq_enable;
  } fcat_cfg_t;

endpackage

// File: rtl/fcat_core.sv
// ----------------------------------------------------------------------------
// fcat_core
// Timer state and the per-item update: prescaler, main counter, compare
// channels and lowest-first alarm dispatch.
// ----------------------------------------------------------------------------
module fcat_core #(
  parameter int unsigned COUNTER_BITS = fcat_pkg::DEF_COUNTER_BITS,
  parameter int unsigned NUM_CHANNELS = fcat_pkg::DEF_NUM_CHANNELS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  input  fcat_pkg::fcat_item_t item,
  input  fcat_pkg::fcat_cfg_t  cfg,
  output fcat_pkg::fcat_result_t res
);
  import fcat_pkg::*;

  logic [PRESCALE_W-1:0]   presc_cnt_r, presc_cnt_nxt;
  logic [COUNTER_BITS-1:0] main_cnt_r, main_cnt_nxt;
  logic [COUNTER_BITS-1:0] cmp_word_r [NUM_CHANNELS];
  logic [COUNTER_BITS-1:0] cmp_word_nxt [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] flag_r, flag_nxt;
  logic [NUM_CHANNELS-1:0] armed_r, armed_nxt;

  logic                    is_tick, is_arm, is_disarm, chan_ok;
  logic                    step;
  logic [COUNTER_BITS-1:0] main_inc;
  logic [COUNTER_BITS-1:0] arm_time;
  logic                    found;
  logic [FCH_W-1:0]        fch;

  always_comb begin
    is_tick   = 1'b0;
    is_arm    = 1'b0;
    is_disarm = 1'b0;
    unique case (item.op)
      OP_TICK:    is_tick = 1'b1;
      OP_ARM_ABS,
      OP_ARM_REL: is_arm = 1'b1;
      OP_DISARM:  is_disarm = 1'b1;
      default:    ;
    endcase
  end

  assign chan_ok  = 32'(item.channel) < NUM_CHANNELS;
  assign step     = is_tick && cfg.counter_enable && (presc_cnt_r >= cfg.prescaler);
  assign main_inc = main_cnt_r + COUNTER_BITS'(1);
  // relative arm lands at now + timeout - 1
  assign arm_time = (item.op == OP_ARM_REL) ?
                    main_cnt_r + item.value[COUNTER_BITS-1:0] - COUNTER_BITS'(1) :
                    item.value[COUNTER_BITS-1:0];

  always_comb begin
    presc_cnt_nxt = presc_cnt_r;
    main_cnt_nxt  = main_cnt_r;
    if (is_tick && cfg.counter_enable) begin
      if (step) begin
        presc_cnt_nxt = '0;
        main_cnt_nxt  = main_inc;
      end else begin
        presc_cnt_nxt = presc_cnt_r + PRESCALE_W'(1);
      end
    end
  end

  always_comb begin
    found = 1'b0;
    fch   = '0;
    for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
      cmp_word_nxt[ch] = cmp_word_r[ch];
      flag_nxt[ch]     = flag_r[ch];
      armed_nxt[ch]    = armed_r[ch];
      if (step && armed_r[ch] && (cmp_word_r[ch] == main_inc)) begin
        flag_nxt[ch] = 1'b1;
      end
      if (item.channel == CHAN_W'(ch)) begin
        if (is_arm) begin
          cmp_word_nxt[ch] = arm_time;
          flag_nxt[ch]     = 1'b0;
          armed_nxt[ch]    = 1'b1;
        end else if (is_disarm) begin
          armed_nxt[ch] = 1'b0;
        end
      end
    end
    // lowest pending channel goes first
    if (cfg.alarm_irq_enable) begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        if (!found && flag_nxt[ch] && armed_nxt[ch]) begin
          found         = 1'b1;
          fch           = FCH_W'(ch);
          flag_nxt[ch]  = 1'b0;
          armed_nxt[ch] = 1'b0;
        end
      end
    end
  end

  assign res.counter_value = COUNT_OUT_W'(main_cnt_nxt);
  assign res.fired         = found;
  assign res.fired_channel = fch;
  assign res.error         = (is_arm || is_disarm) && !chan_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      presc_cnt_r <= '0;
      main_cnt_r  <= '0;
      flag_r      <= '0;
      armed_r     <= '0;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        cmp_word_r[ch] <= '0;
      end
    end else if (item_valid) begin
      presc_cnt_r <= presc_cnt_nxt;
      main_cnt_r  <= main_cnt_nxt;
      flag_r      <= flag_nxt;
      armed_r     <= armed_nxt;
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
        cmp_word_r[ch] <= cmp_word_nxt[ch];
      end
    end
  end

  a_fire_needs_enable: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && res.fired |-> cfg.alarm_irq_enable)
    else $error("alarm dispatched while dispatch disabled");

  a_error_only_on_channel_ops: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && res.error |->
      (item.op == OP_ARM_ABS || item.op == OP_ARM_REL || item.op == OP_DISARM))
    else $error("error flagged on an op without a channel");

  a_count_holds_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.op != OP_TICK |=> $stable(main_cnt_r))
    else $error("main counter moved on a non-tick item");

  a_fast_tick_steps: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item.op == OP_TICK && cfg.counter_enable && cfg.prescaler == '0
    |=> main_cnt_r != $past(main_cnt_r))
    else $error("tick with prescaler zero did not step counter");

endmodule

// File: rtl/four_channel_compare_alarm_timer.sv
// ----------------------------------------------------------------------------
// four_channel_compare_alarm_timer
// Prescaled up-counter with one-shot compare alarms, item in / result out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel: one item per handshake (tick, arm absolute, arm relative,
//         disarm, read). Every item gives exactly one result on out_*.
//   cfg_* channel: register writes (0 prescaler, 1 counter enable, 2 alarm
//         dispatch enable), always ready; write only while the timer is idle.
//   An accepted item waits in the input register; the core processes it as it
//   moves into the result register, which then holds its result.
//   Throughput: one item per cycle while out_ready is high; the counter,
//   compare words and dispatch logic between the input register and the
//   result register are combinational.
//   Stall: while a valid result sees out_ready low the result register holds;
//   one further item waits in the input register and in_ready then drops.
//   Reset: rst_n low clears counters, compare words, flags, arming, the
//   configuration registers and both valid bits.
// ----------------------------------------------------------------------------
module four_channel_compare_alarm_timer #(
  parameter int unsigned COUNTER_BITS = fcat_pkg::DEF_COUNTER_BITS,
  parameter int unsigned NUM_CHANNELS = fcat_pkg::DEF_NUM_CHANNELS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fcat_pkg::OP_W-1:0]         in_op,
  input  logic [fcat_pkg::CHAN_W-1:0]       in_channel,
  input  logic [fcat_pkg::VALUE_W-1:0]      in_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fcat_pkg::COUNT_OUT_W-1:0]  out_counter_value,
  output logic                              out_fired,
  output logic [fcat_pkg::FCH_W-1:0]        out_fired_channel,
  output logic                              out_error,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcat_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import fcat_pkg::*;

  fcat_item_t   in_item_r;
  logic         in_valid_r;
  fcat_result_t res, out_res_r;
  logic         out_valid_r;
  fcat_cfg_t    cfg_r;
  logic         advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r.op      <= in_op;
      in_item_r.channel <= in_channel;
      in_item_r.value   <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PRESCALER:  cfg_r.prescaler        <= cfg_wdata;
        CFG_COUNTER_EN: cfg_r.counter_enable   <= cfg_wdata[0];
        CFG_ALARM_EN:   cfg_r.alarm_irq_enable <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  fcat_core #(
    .COUNTER_BITS(COUNTER_BITS),
    .NUM_CHANNELS(NUM_CHANNELS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_valid(advance),
    .item      (in_item_r),
    .cfg       (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_counter_value = out_res_r.counter_value;
  assign out_fired         = out_res_r.fired;
  assign out_fired_channel = out_res_r.fired_channel;
  assign out_error         = out_res_r.error;

endmodule
